@@ rtl/mdpp_pkg.sv @@
// Shared constants and types for the minimum distance point placement block.
package mdpp_pkg;

  // Store geometry
  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // Field widths
  localparam int COORD_W = 16;
  localparam int POINT_W = 3 * COORD_W;
  localparam int SQ_W    = 32;
  localparam int DIST_W  = 34;
  localparam int SLOT_W  = 6;
  localparam int PC_W    = 7;
  localparam int SEP_W   = 16;
  localparam int ATT_W   = 24;

  // Nearest distance reported when no point is stored
  localparam logic [DIST_W-1:0] NONE_SQ = 34'd12884508675;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SEP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS = 2'd2;

  localparam logic [PC_W-1:0]  RST_POINT_COUNT  = 7'd64;
  localparam logic [SEP_W-1:0] RST_MIN_SEP      = 16'd256;
  localparam logic [ATT_W-1:0] RST_MAX_ATTEMPTS = 24'd1000000;

  // Configuration register set
  typedef struct packed {
    logic [PC_W-1:0]  point_count;
    logic [SEP_W-1:0] min_sep;
    logic [ATT_W-1:0] max_att;
  } cfg_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic             load;
    logic             restart;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             commit;
    logic [IDX_W-1:0] slot;
    logic             done;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic busy;
    logic accept;
    logic gave_up;
  } sts_t;

endpackage

@@ rtl/mdpp_ctrl.sv @@
// Controller: fill sequencing, store scan addressing and handshakes.
module mdpp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           in_start_new,
  output logic           out_valid,
  input  logic           out_stall,
  input  mdpp_pkg::cfg_t cfg,
  output mdpp_pkg::cmd_t cmd,
  input  mdpp_pkg::sts_t sts
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_DECIDE = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic [mdpp_pkg::CNT_W-1:0]   filled_r, filled_nxt;
  logic [mdpp_pkg::IDX_W-1:0]   slot_r, slot_nxt;
  logic [mdpp_pkg::IDX_W-1:0]   scan_r, scan_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [mdpp_pkg::CNT_W-1:0]   n_eff;
  logic [mdpp_pkg::CNT_W-1:0]   slot_inc;
  logic                         restart;
  logic                         done;

  // Clamp the configured count to 1..MAX_POINTS
  always_comb begin
    if (cfg.point_count == '0) begin
      n_eff = mdpp_pkg::CNT_W'(1);
    end else if (32'(cfg.point_count) > mdpp_pkg::MAX_POINTS) begin
      n_eff = mdpp_pkg::CNT_W'(mdpp_pkg::MAX_POINTS);
    end else begin
      n_eff = mdpp_pkg::CNT_W'(cfg.point_count);
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign restart   = in_start_new || (filled_r >= n_eff);
  assign slot_inc  = mdpp_pkg::CNT_W'(slot_r) + mdpp_pkg::CNT_W'(1);
  assign done      = sts.accept && (slot_inc >= n_eff);

  // Sequence one candidate: load, scan filled slots, drain, decide
  always_comb begin
    state_nxt     = state_r;
    filled_nxt    = filled_r;
    slot_nxt      = slot_r;
    scan_nxt      = scan_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.rd_addr   = scan_r;
    cmd.slot      = slot_r;
    cmd.done      = done;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.restart = restart;
          slot_nxt    = restart ? '0 : filled_r[mdpp_pkg::IDX_W-1:0];
          filled_nxt  = restart ? '0 : filled_r;
          scan_nxt    = '0;
          state_nxt   = (slot_nxt == '0) ? ST_DECIDE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (scan_r == mdpp_pkg::IDX_W'(slot_r - 1'b1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!sts.busy) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // Hold the decision until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (sts.gave_up || done) begin
            filled_nxt = '0;
          end else if (sts.accept) begin
            filled_nxt = slot_inc;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      filled_r    <= '0;
      slot_r      <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      filled_r    <= filled_nxt;
      slot_r      <= slot_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/mdpp_dpath.sv @@
// Datapath: point store, pipelined squared distance unit, minimum and decision.
module mdpp_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mdpp_pkg::cfg_t                      cfg,
  input  mdpp_pkg::cmd_t                      cmd,
  output mdpp_pkg::sts_t                      sts,
  input  logic signed [mdpp_pkg::COORD_W-1:0] in_pos_x,
  input  logic signed [mdpp_pkg::COORD_W-1:0] in_pos_y,
  input  logic signed [mdpp_pkg::COORD_W-1:0] in_pos_z,
  output logic                                out_accepted,
  output logic [mdpp_pkg::SLOT_W-1:0]         out_slot_index,
  output logic [mdpp_pkg::DIST_W-1:0]         out_nearest_sq,
  output logic                                out_cluster_done,
  output logic                                out_gave_up
);

  localparam int CW = mdpp_pkg::COORD_W;

  logic [mdpp_pkg::POINT_W-1:0] mem [mdpp_pkg::MAX_POINTS];

  logic signed [CW-1:0]          cx_r, cy_r, cz_r;
  logic [mdpp_pkg::POINT_W-1:0]  rd_data_r;
  logic                          rd_v_r;
  logic [mdpp_pkg::SQ_W-1:0]     sq_x_r, sq_y_r, sq_z_r;
  logic                          sq_v_r;
  logic [mdpp_pkg::SQ_W-1:0]     sq_x, sq_y, sq_z;
  logic [CW-1:0]                 mx, my, mz;
  logic [mdpp_pkg::DIST_W-1:0]   dist_sum;
  logic [mdpp_pkg::DIST_W-1:0]   min_r;
  logic [mdpp_pkg::ATT_W-1:0]    attempt_r;
  logic [mdpp_pkg::ATT_W:0]      att_inc;
  logic [mdpp_pkg::SQ_W-1:0]     sep_sq_r;
  logic [mdpp_pkg::SQ_W-1:0]     sep_prod;
  logic                          gave_up;
  logic                          accept;

  logic                          acc_r;
  logic [mdpp_pkg::SLOT_W-1:0]   slot_out_r;
  logic [mdpp_pkg::DIST_W-1:0]   near_out_r;
  logic                          done_out_r;
  logic                          gave_out_r;

  // Magnitude of a 17-bit coordinate difference
  function automatic logic [CW-1:0] abs_diff(input logic signed [CW-1:0] a,
                                             input logic signed [CW-1:0] b);
    logic signed [CW:0] d;
    logic signed [CW:0] nd;
    d  = {a[CW-1], a} - {b[CW-1], b};
    nd = -d;
    return d[CW] ? nd[CW-1:0] : d[CW-1:0];
  endfunction

  // Capture the candidate
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r <= in_pos_x;
      cy_r <= in_pos_y;
      cz_r <= in_pos_z;
    end
  end

  // Point store: write on acceptance, registered read during the scan
  always_ff @(posedge clk) begin
    if (cmd.commit && accept) begin
      mem[cmd.slot] <= {cz_r, cy_r, cx_r};
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_addr];
    end
  end

  // Per-axis squares of the difference
  always_comb begin
    mx   = abs_diff(cx_r, rd_data_r[CW-1:0]);
    my   = abs_diff(cy_r, rd_data_r[2*CW-1:CW]);
    mz   = abs_diff(cz_r, rd_data_r[3*CW-1:2*CW]);
    sq_x = mx * mx;
    sq_y = my * my;
    sq_z = mz * mz;
  end

  always_ff @(posedge clk) begin
    sq_x_r <= sq_x;
    sq_y_r <= sq_y;
    sq_z_r <= sq_z;
  end

  assign dist_sum = mdpp_pkg::DIST_W'(sq_x_r) + mdpp_pkg::DIST_W'(sq_y_r)
                  + mdpp_pkg::DIST_W'(sq_z_r);

  // Track the nearest stored point
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      min_r <= mdpp_pkg::NONE_SQ;
    end else if (sq_v_r && (dist_sum < min_r)) begin
      min_r <= dist_sum;
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      sq_v_r <= 1'b0;
    end else begin
      rd_v_r <= cmd.rd_en;
      sq_v_r <= rd_v_r;
    end
  end

  // Squared separation, refreshed from the register every cycle
  assign sep_prod = cfg.min_sep * cfg.min_sep;
  always_ff @(posedge clk) begin
    sep_sq_r <= sep_prod;
  end

  // Decide: give up past the attempt limit, else accept unless too close
  assign att_inc = {1'b0, attempt_r} + 1'b1;
  assign gave_up = att_inc > {1'b0, cfg.max_att};
  assign accept  = !gave_up && (min_r >= mdpp_pkg::DIST_W'(sep_sq_r));

  assign sts.busy    = rd_v_r || sq_v_r;
  assign sts.accept  = accept;
  assign sts.gave_up = gave_up;

  // Attempt counter for the current slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attempt_r <= '0;
    end else if (cmd.load && cmd.restart) begin
      attempt_r <= '0;
    end else if (cmd.commit) begin
      attempt_r <= (gave_up || accept) ? '0 : att_inc[mdpp_pkg::ATT_W-1:0];
    end
  end

  // Result beat payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      acc_r      <= accept;
      slot_out_r <= mdpp_pkg::SLOT_W'(cmd.slot);
      near_out_r <= min_r;
      done_out_r <= cmd.done;
      gave_out_r <= gave_up;
    end
  end

  assign out_accepted     = acc_r;
  assign out_slot_index   = slot_out_r;
  assign out_nearest_sq   = near_out_r;
  assign out_cluster_done = done_out_r;
  assign out_gave_up      = gave_out_r;

endmodule

@@ rtl/min_distance_point_placement.sv @@
// Top level of the minimum distance point placement block.
// Each candidate beat is tested against the points already stored in the
// current cluster, one stored point per cycle through a single shared
// squared-distance unit. With points stored, each stored point is read into
// the store read register, squared into the per-axis square registers and
// folded into the running minimum before the decision; with the cluster empty
// there is nothing to scan and the candidate goes straight to the decision.
// The scan length grows with the points stored. One candidate is in flight
// at a time, and a new one is taken while the last result beat still waits
// on out_stall. Configuration writes are always taken (cfg_ready is tied
// high) and must be issued only while idle.
module min_distance_point_placement (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_start_new,
  input  logic signed [mdpp_pkg::COORD_W-1:0]   in_pos_x,
  input  logic signed [mdpp_pkg::COORD_W-1:0]   in_pos_y,
  input  logic signed [mdpp_pkg::COORD_W-1:0]   in_pos_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_accepted,
  output logic [mdpp_pkg::SLOT_W-1:0]           out_slot_index,
  output logic [mdpp_pkg::DIST_W-1:0]           out_nearest_sq,
  output logic                                  out_cluster_done,
  output logic                                  out_gave_up,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mdpp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mdpp_pkg::CFG_DATA_W-1:0]       cfg_data
);

  mdpp_pkg::cfg_t cfg_r;
  mdpp_pkg::cmd_t cmd;
  mdpp_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.point_count <= mdpp_pkg::RST_POINT_COUNT;
      cfg_r.min_sep     <= mdpp_pkg::RST_MIN_SEP;
      cfg_r.max_att     <= mdpp_pkg::RST_MAX_ATTEMPTS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mdpp_pkg::REG_POINT_COUNT: begin
          cfg_r.point_count <= cfg_data[mdpp_pkg::PC_W-1:0];
        end
        mdpp_pkg::REG_MIN_SEP: begin
          cfg_r.min_sep <= cfg_data[mdpp_pkg::SEP_W-1:0];
        end
        mdpp_pkg::REG_MAX_ATTEMPTS: begin
          cfg_r.max_att <= cfg_data[mdpp_pkg::ATT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  mdpp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_start_new (in_start_new),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cfg          (cfg_r),
    .cmd          (cmd),
    .sts          (sts)
  );

  mdpp_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cmd              (cmd),
    .sts              (sts),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .out_accepted     (out_accepted),
    .out_slot_index   (out_slot_index),
    .out_nearest_sq   (out_nearest_sq),
    .out_cluster_done (out_cluster_done),
    .out_gave_up      (out_gave_up)
  );

  // One candidate in flight: an accepted beat blocks the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a candidate is in flight");

  // A result never both stores the point and gives up
  a_accept_xor_giveup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_accepted && out_gave_up))
    else $error("result both accepted and gave up");

  // Completion only on an acceptance
  a_done_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_cluster_done) |-> out_accepted)
    else $error("cluster done without acceptance");

endmodule
